// File: hdl/pcat_pkg.sv
package pcat_pkg;

  localparam int ADC_W   = 12;
  localparam int DIFF_W  = 14;
  localparam int PROD_W  = 27;
  localparam int CUR_W   = 18;
  localparam int MAG_W   = 17;
  localparam int MEAN_W  = 18;
  localparam int POWER_W = 22;
  localparam int THR_W   = 16;

  localparam logic [DIFF_W-1:0] ADC_FULL   = 14'd4095;
  localparam logic [PROD_W-1:0] SCALE_NUM  = 27'd4421;
  localparam int                SCALE_SHR  = 8;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'hFFFF;

  typedef logic [ADC_W-1:0]          adc_t;
  typedef logic signed [CUR_W-1:0]   cur_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic signed [MEAN_W-1:0]  mean_t;
  typedef logic signed [POWER_W-1:0] power_t;
  typedef logic [THR_W-1:0]          thr_t;

endpackage

// File: hdl/pcat_chan_if.sv
interface pcat_in_if;
  import pcat_pkg::*;

  logic valid;
  logic ready;
  adc_t adc_phase_b;
  adc_t adc_phase_c;

  modport source (output valid, output adc_phase_b, output adc_phase_c, input ready);
  modport sink (input valid, input adc_phase_b, input adc_phase_c, output ready);
endinterface

interface pcat_out_if;
  import pcat_pkg::*;

  logic   valid;
  logic   ready;
  mean_t  mean_current_ma;
  power_t power_mw;
  logic   check_done;
  logic   trip;

  modport source (output valid, output mean_current_ma, output power_mw,
                  output check_done, output trip, input ready);
  modport sink (input valid, input mean_current_ma, input power_mw,
                input check_done, input trip, output ready);
endinterface

// File: hdl/pcat_recip_div.sv
module pcat_recip_div #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 22
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [SUM_W-1:0]  sum_i,
  output pcat_pkg::mag_t           quot_o,
  output logic                     neg_o
);
  import pcat_pkg::*;

  // exact floor(n / WINDOW) for n < 2^ABS_W via ceil(2^S / WINDOW)
  localparam int ABS_W  = SUM_W - 1;
  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SHIFT  = ABS_W + LOG_W;
  localparam int M_W    = ABS_W + 1;
  localparam int MUL_W  = ABS_W + M_W;
  localparam logic [63:0] RECIP_64 = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [M_W-1:0] RECIP = RECIP_64[M_W-1:0];

  logic [SUM_W-1:0] abs_full;
  logic [ABS_W-1:0] abs_val;
  logic [MUL_W-1:0] prod;
  mag_t             quot_r;
  logic             neg_r;

  assign abs_full = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign abs_val  = abs_full[ABS_W-1:0];
  assign prod     = MUL_W'(abs_val) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      quot_r <= prod[SHIFT +: MAG_W];
      neg_r  <= sum_i[SUM_W-1];
    end
  end

  assign quot_o = quot_r;
  assign neg_o  = neg_r;

endmodule

// File: hdl/phase_current_average_trip_core.sv
// Throughput: one word per cycle while the sink holds out_ch.ready high; a five-stage
// pipeline with per-stage valids, so input stays ready while a finished result waits
// as long as a stage is free. Reset (synchronous, rst_n low): pipeline emptied, sample
// line and running sum cleared to zero, check counter to zero, threshold to 65535.
module phase_current_average_trip_core #(
  parameter int WINDOW       = 10,
  parameter int CHECK_PERIOD = 51
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pcat_in_if.sink              in_ch,
  pcat_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  pcat_pkg::thr_t       cfg_wr_data
);
  import pcat_pkg::*;

  localparam int SUM_W = CUR_W + $clog2(WINDOW);
  localparam int CNT_W = (CHECK_PERIOD > 1) ? $clog2(CHECK_PERIOD) : 1;
  localparam int NSTG  = 5;

  logic [NSTG-1:0] vld_r, vld_nxt, mv;

  thr_t thr_r;

  adc_t b_r, c_r;

  logic [DIFF_W-1:0]        diff;
  logic signed [PROD_W-1:0] prod;
  cur_t                     cur_r;

  cur_t                    tap_r [WINDOW];
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    done2_r, done2_nxt;

  mag_t quot;
  logic neg;
  logic done3_r;

  mean_t  mean_nxt, mean_r;
  power_t power_nxt, power_r;
  logic   trip_nxt, trip_r, done4_r;

  // stage advance chain, last stage drains into the sink
  always_comb begin
    mv[NSTG-1] = vld_r[NSTG-1] && out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      mv[k] = vld_r[k] && (!vld_r[k+1] || mv[k+1]);
    end
  end

  assign in_ch.ready = !vld_r[0] || mv[0];

  always_comb begin
    vld_nxt[0] = (vld_r[0] && !mv[0]) || (in_ch.valid && in_ch.ready);
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = (vld_r[k] && !mv[k]) || mv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= THR_RESET;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      b_r <= in_ch.adc_phase_b;
      c_r <= in_ch.adc_phase_c;
    end
  end

  // stage 1: scale to mA, floor by arithmetic shift
  assign diff = ADC_FULL - (DIFF_W'(b_r) + DIFF_W'(c_r));
  assign prod = signed'(PROD_W'(signed'(diff))) * signed'(SCALE_NUM);

  always_ff @(posedge clk) begin
    if (mv[0]) begin
      cur_r <= prod[SCALE_SHR +: CUR_W];
    end
  end

  // stage 2: sample line, running sum, check counter
  assign sum_nxt = sum_r - SUM_W'(tap_r[WINDOW-1]) + SUM_W'(cur_r);

  always_comb begin
    if (cnt_r == CNT_W'(CHECK_PERIOD - 1)) begin
      cnt_nxt   = '0;
      done2_nxt = 1'b1;
    end else begin
      cnt_nxt   = cnt_r + CNT_W'(1);
      done2_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        tap_r[i] <= '0;
      end
    end else if (mv[1]) begin
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      tap_r[0] <= cur_r;
      for (int i = 1; i < WINDOW; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv[1]) begin
      done2_r <= done2_nxt;
    end
  end

  // stage 3: mean magnitude by reciprocal multiply
  pcat_recip_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_div (
    .clk    (clk),
    .load   (mv[2]),
    .sum_i  (sum_r),
    .quot_o (quot),
    .neg_o  (neg)
  );

  always_ff @(posedge clk) begin
    if (mv[2]) begin
      done3_r <= done2_r;
    end
  end

  // stage 4: sign, power, threshold check
  assign mean_nxt  = neg ? -mean_t'(MEAN_W'(quot)) : mean_t'(MEAN_W'(quot));
  assign power_nxt = (POWER_W'(mean_nxt) <<< 4) + (POWER_W'(mean_nxt) <<< 3);
  assign trip_nxt  = done3_r && !neg && (quot > MAG_W'(thr_r));

  always_ff @(posedge clk) begin
    if (mv[3]) begin
      mean_r  <= mean_nxt;
      power_r <= power_nxt;
      done4_r <= done3_r;
      trip_r  <= trip_nxt;
    end
  end

  assign out_ch.valid           = vld_r[NSTG-1];
  assign out_ch.mean_current_ma = mean_r;
  assign out_ch.power_mw        = power_r;
  assign out_ch.check_done      = done4_r;
  assign out_ch.trip            = trip_r;

  a_trip_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] && trip_r |-> done4_r && !mean_r[MEAN_W-1])
    else $error("trip without a check or with negative mean");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && in_ch.ready)
    else $error("pipeline not empty after reset");

  a_no_word_lost: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && !mv[0] |=> vld_r[0] && $stable(b_r) && $stable(c_r))
    else $error("stalled input word dropped");

  a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
    mv[1] && done2_nxt |=> cnt_r == '0 && done2_r)
    else $error("check period not restarted");

endmodule
